/* rtl/hbd_pkg.sv */
// Package for the Huffman bit decoder.
// Field widths and the structs passed between the top level and its compare cells.
// No dependencies.
`default_nettype none

package hbd_pkg;

    localparam int IDX_W  = 8;
    localparam int SYM_W  = 8;
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    // Table write broadcast to every cell
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  index;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  length;
    } load_t;

    // Search token handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [SYM_W-1:0] symbol;
    } token_t;

endpackage

`default_nettype wire

/* rtl/hbd_in_if.sv */
// Input channel of the Huffman bit decoder: valid/ready plus one item.
// Depends on hbd_pkg for field widths.
`default_nettype none

interface hbd_in_if;
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [hbd_pkg::IDX_W-1:0]  entry_index;
    logic [hbd_pkg::SYM_W-1:0]  entry_symbol;
    logic [hbd_pkg::CODE_W-1:0] entry_code;
    logic [hbd_pkg::LEN_W-1:0]  entry_length;
    logic                       code_bit;

    modport source (
        output valid, func, entry_index, entry_symbol, entry_code, entry_length, code_bit,
        input  ready
    );
    modport sink (
        input  valid, func, entry_index, entry_symbol, entry_code, entry_length, code_bit,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/hbd_out_if.sv */
// Output channel of the Huffman bit decoder: valid/ready plus one result.
// Depends on hbd_pkg for field widths.
`default_nettype none

interface hbd_out_if;
    logic                      valid;
    logic                      ready;
    logic [hbd_pkg::SYM_W-1:0] symbol;
    logic                      code_error;

    modport source (
        output valid, symbol, code_error,
        input  ready
    );
    modport sink (
        input  valid, symbol, code_error,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/hbd_cell.sv */
// One table slot of the Huffman bit decoder with its code compare.
// Passes the search token to the next slot each cycle. Depends on hbd_pkg.
`default_nettype none

module hbd_cell #(
    parameter int CELL_INDEX = 0,
    parameter int ACC_W      = 32,
    parameter int CNT_W      = 6
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire hbd_pkg::load_t             load,
    input  wire logic [ACC_W-1:0]           query_bits,
    input  wire logic [CNT_W-1:0]           query_count,
    input  wire hbd_pkg::token_t            tok_in,
    output hbd_pkg::token_t                 tok_out
);

    logic [hbd_pkg::SYM_W-1:0] sym_reg;
    logic [ACC_W-1:0]          code_reg;
    logic [hbd_pkg::LEN_W-1:0] len_reg;
    logic [ACC_W-1:0]          len_mask;
    logic                      slot_sel;
    logic                      match;
    hbd_pkg::token_t           tok_reg;
    hbd_pkg::token_t           tok_next;

    assign slot_sel = load.we && (load.index == hbd_pkg::IDX_W'(CELL_INDEX));

    always_comb
    begin
        for (int k = 0; k < ACC_W; k++)
        begin
            len_mask[k] = hbd_pkg::LEN_W'(k) < len_reg;
        end
    end

    // count is never zero during a search, so an empty slot cannot match
    assign match = (len_reg == hbd_pkg::LEN_W'(query_count))
                && (((code_reg ^ query_bits) & len_mask) == '0);

    always_comb
    begin
        tok_next.valid  = tok_in.valid;
        tok_next.hit    = tok_in.hit || match;
        tok_next.symbol = tok_in.hit ? tok_in.symbol : sym_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (slot_sel)
            begin
                len_reg <= load.length;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_sel)
        begin
            sym_reg  <= load.symbol;
            code_reg <= load.code[ACC_W-1:0];
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

/* rtl/huffman_bit_decoder.sv */
// Huffman bit decoder: item channel in, result channel out.
// A load beat (func 0) writes one table slot: symbol, right-aligned code and
// code length (length 0 leaves the slot empty). A decode beat (func 1)
// shifts one code bit into the accumulator, first bit highest.
// When the accumulated bits equal a slot's code at that slot's length, the
// lowest-index matching slot's symbol goes out with code_error 0 and the
// accumulator clears; when nothing matches and the accumulator holds the
// maximum code length, symbol 0 with code_error 1 goes out and it clears.
// Load beats give no result. A decode beat launches a search token that
// walks the row of slot cells, one cell per cycle. One decode beat is in
// flight at a time; ready stays low while it searches.
// The result sits in an output register; loads are still taken while it
// waits. A search that finishes while the receiver stalls a previous result
// holds until that result is taken.
// Reset empties every slot and clears the accumulator and the output.
// Depends on hbd_pkg, hbd_in_if, hbd_out_if and hbd_cell.
`default_nettype none

module huffman_bit_decoder #(
    parameter int TABLE_ENTRIES = 256,
    parameter int MAX_CODE_LEN  = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    hbd_in_if.sink     item,
    hbd_out_if.source  result
);

    localparam int ACC_LIMIT = (MAX_CODE_LEN > 32) ? 32 : MAX_CODE_LEN;
    localparam int ACC_W     = ACC_LIMIT;
    localparam int CNT_W     = $clog2(ACC_LIMIT + 1);

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_SEARCH  = 3'b010,
        ST_RESOLVE = 3'b100
    } state_t;

    state_t                    state_reg, state_next;
    logic [ACC_W-1:0]          pending_bits_reg, pending_bits_next;
    logic [CNT_W-1:0]          pending_count_reg, pending_count_next;
    logic                      launch_reg;
    logic                      hit_reg;
    logic [hbd_pkg::SYM_W-1:0] hit_sym_reg;
    logic                      out_valid_reg, out_valid_next;
    logic [hbd_pkg::SYM_W-1:0] symbol_reg;
    logic                      code_error_reg;
    logic                      accept;
    logic                      accept_decode;
    logic                      need_result;
    logic                      out_free;
    logic                      emit;
    hbd_pkg::load_t            load_bcast;
    hbd_pkg::token_t           launch_tok;
    hbd_pkg::token_t           chain_tok [TABLE_ENTRIES+1];

    assign item.ready    = (state_reg == ST_IDLE);
    assign accept        = item.valid && item.ready;
    assign accept_decode = accept && (item.func == hbd_pkg::FUNC_DECODE);

    always_comb
    begin
        load_bcast.we     = accept && (item.func == hbd_pkg::FUNC_LOAD);
        load_bcast.index  = item.entry_index;
        load_bcast.symbol = item.entry_symbol;
        load_bcast.code   = item.entry_code;
        load_bcast.length = item.entry_length;
    end

    always_comb
    begin
        launch_tok.valid  = launch_reg;
        launch_tok.hit    = 1'b0;
        launch_tok.symbol = '0;
    end

    assign chain_tok[0] = launch_tok;

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        hbd_cell #(
            .CELL_INDEX (i),
            .ACC_W      (ACC_W),
            .CNT_W      (CNT_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .load        (load_bcast),
            .query_bits  (pending_bits_reg),
            .query_count (pending_count_reg),
            .tok_in      (chain_tok[i]),
            .tok_out     (chain_tok[i+1])
        );
    end

    assign need_result = hit_reg || (pending_count_reg == CNT_W'(ACC_LIMIT));
    assign out_free    = !out_valid_reg || result.ready;
    assign emit        = (state_reg == ST_RESOLVE) && need_result && out_free;

    always_comb
    begin
        state_next         = state_reg;
        pending_bits_next  = pending_bits_reg;
        pending_count_next = pending_count_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_decode)
                begin
                    pending_bits_next  = {pending_bits_reg[ACC_W-2:0], item.code_bit};
                    pending_count_next = pending_count_reg + 1'b1;
                    state_next         = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (chain_tok[TABLE_ENTRIES].valid)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                if (!need_result)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    pending_bits_next  = '0;
                    pending_count_next = '0;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            pending_bits_reg  <= '0;
            pending_count_reg <= '0;
            launch_reg        <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            pending_bits_reg  <= pending_bits_next;
            pending_count_reg <= pending_count_next;
            launch_reg        <= accept_decode;
            out_valid_reg     <= out_valid_next;
        end
    end

    // capture the token at the end of the row, load the output on emit
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_SEARCH) && chain_tok[TABLE_ENTRIES].valid)
        begin
            hit_reg     <= chain_tok[TABLE_ENTRIES].hit;
            hit_sym_reg <= chain_tok[TABLE_ENTRIES].symbol;
        end
        if (emit)
        begin
            symbol_reg     <= hit_reg ? hit_sym_reg : '0;
            code_error_reg <= !hit_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.symbol     = symbol_reg;
    assign result.code_error = code_error_reg;

endmodule

`default_nettype wire

/* rtl/hbd_checker.sv */
// Port-level checks for the Huffman bit decoder, bound to the top level.
// Depends on hbd_pkg and huffman_bit_decoder.
`default_nettype none

module hbd_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      item_valid,
    input wire logic                      item_ready,
    input wire logic                      item_func,
    input wire logic                      result_valid,
    input wire logic                      result_ready,
    input wire logic [hbd_pkg::SYM_W-1:0] result_symbol,
    input wire logic                      result_code_error
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_symbol)
            && $stable(result_code_error))
    else $error("stalled result beat changed or dropped");

    // a code error carries symbol zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_code_error |-> result_symbol == '0)
    else $error("code error with nonzero symbol");

    // a decode beat starts a search, so the input closes
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item_func == hbd_pkg::FUNC_DECODE) |=> !item_ready)
    else $error("input still open after a decode beat");

    // a load beat finishes at once and the input stays open
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item_func == hbd_pkg::FUNC_LOAD) |=> item_ready)
    else $error("input closed after a load beat");

    // a new result appears only after a search, never right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && !result_valid |=> !result_valid)
    else $error("result appeared one cycle after an accept");

endmodule

bind huffman_bit_decoder hbd_checker u_hbd_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (item.valid),
    .item_ready        (item.ready),
    .item_func         (item.func),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .result_symbol     (result.symbol),
    .result_code_error (result.code_error)
);

`default_nettype wire

/* test/huffman_bit_decoder_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for huffman_bit_decoder: directed table, then random prefix-code
// phases checked against a behavioral copy of the decoder. Depends on hbd_pkg, hbd_in_if,
// hbd_out_if and the RTL of the block.

module huffman_bit_decoder_tb;

    localparam int   IDX_W         = hbd_pkg::IDX_W;
    localparam int   SYM_W         = hbd_pkg::SYM_W;
    localparam int   CODE_W        = hbd_pkg::CODE_W;
    localparam int   LEN_W         = hbd_pkg::LEN_W;
    localparam logic FUNC_LOAD     = hbd_pkg::FUNC_LOAD;
    localparam logic FUNC_DECODE   = hbd_pkg::FUNC_DECODE;

    localparam int TABLE_ENTRIES = 256;
    localparam int MAX_CODE_LEN  = 32;
    localparam int ACC_LIMIT     = (MAX_CODE_LEN > 32) ? 32 : MAX_CODE_LEN;
    localparam int RANDOM_BEATS  = 1600;
    localparam int IDLE_LIMIT    = 8000;
    localparam int HOLD_CYCLES   = 700;
    localparam int DIR_ROWS      = 18;

    typedef struct packed {
        logic              func;
        logic [IDX_W-1:0]  index;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  length;
        logic              stream_bit;
    } beat_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             code_error;
    } result_t;

    typedef struct packed {
        logic              func;
        logic [IDX_W-1:0]  index;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  length;
        logic              stream_bit;
        logic              typed;
        logic [SYM_W-1:0]  exp_symbol;
        logic              exp_error;
    } dir_row_t;

    // typed rows: single-bit codes, lowest index on ties, a two-bit code
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{FUNC_LOAD,   8'd255, 8'hAA, 32'hFFFF_FFFE, 6'd1,  1'b0, 1'b0, 8'h00, 1'b0},
        '{FUNC_LOAD,   8'd0,   8'h55, 32'h0000_0001, 6'd1,  1'b0, 1'b0, 8'h00, 1'b0},
        '{FUNC_DECODE, 8'd0,   8'h00, 32'h0000_0000, 6'd0,  1'b0, 1'b1, 8'hAA, 1'b0},
        '{FUNC_DECODE, 8'd0,   8'h00, 32'h0000_0000, 6'd0,  1'b1, 1'b1, 8'h55, 1'b0},
        '{FUNC_LOAD,   8'd3,   8'h11, 32'h0000_0000, 6'd1,  1'b0, 1'b0, 8'h00, 1'b0},
        '{FUNC_DECODE, 8'd0,   8'h00, 32'h0000_0000, 6'd0,  1'b0, 1'b1, 8'h11, 1'b0},
        '{FUNC_LOAD,   8'd2,   8'hEE, 32'hFFFF_FFFF, 6'd63, 1'b0, 1'b0, 8'h00, 1'b0},
        '{FUNC_LOAD,   8'd1,   8'h77, 32'h7FFF_FFFF, 6'd33, 1'b0, 1'b0, 8'h00, 1'b0},
        '{FUNC_LOAD,   8'd0,   8'h80, 32'h0000_0002, 6'd2,  1'b0, 1'b0, 8'h00, 1'b0},
        '{FUNC_DECODE, 8'd0,   8'h00, 32'h0000_0000, 6'd0,  1'b1, 1'b0, 8'h00, 1'b0},
        '{FUNC_DECODE, 8'd0,   8'h00, 32'h0000_0000, 6'd0,  1'b0, 1'b1, 8'h80, 1'b0},
        '{FUNC_LOAD,   8'd0,   8'hFF, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 8'h00, 1'b0},
        '{FUNC_DECODE, 8'd0,   8'h00, 32'h0000_0000, 6'd0,  1'b1, 1'b0, 8'h00, 1'b0},
        '{FUNC_DECODE, 8'd0,   8'h00, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 8'h00, 1'b0},
        '{FUNC_LOAD,   8'd3,   8'h00, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 8'h00, 1'b0},
        '{FUNC_LOAD,   8'd255, 8'h00, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 8'h00, 1'b0},
        '{FUNC_LOAD,   8'd2,   8'h00, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 8'h00, 1'b0},
        '{FUNC_LOAD,   8'd1,   8'h00, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 8'h00, 1'b0}
    };

    logic clk;
    logic rst_n;

    hbd_in_if  item_ch ();
    hbd_out_if result_ch ();

    huffman_bit_decoder #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_CODE_LEN  (MAX_CODE_LEN)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // decoder state as the block should hold it
    logic [SYM_W-1:0]  slot_symbol [TABLE_ENTRIES];
    logic [CODE_W-1:0] slot_code   [TABLE_ENTRIES];
    logic [LEN_W-1:0]  slot_length [TABLE_ENTRIES];
    logic [31:0]       acc_bits;
    logic [5:0]        acc_count;

    result_t expected_symbols [$];
    int      fail_count;
    int      beats_sent;
    int      burst_left;
    int      idle_cycles;
    bit      offering;
    bit      hold_off_req;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic void advance_decoder(input beat_t b, output bit produced,
                                            output result_t r);
        logic [31:0] mask;
        int          len;
        produced = 1'b0;
        r        = '0;
        if (b.func == FUNC_LOAD)
        begin
            if (int'(b.index) < TABLE_ENTRIES)
            begin
                slot_symbol[b.index] = b.symbol;
                slot_code[b.index]   = b.code;
                slot_length[b.index] = b.length;
            end
        end
        else
        begin
            acc_bits  = {acc_bits[30:0], b.stream_bit};
            acc_count = acc_count + 6'd1;
            for (int s = 0; s < TABLE_ENTRIES; s++)
            begin
                len = int'(slot_length[s]);
                if (!produced && len != 0 && len <= ACC_LIMIT && len == int'(acc_count))
                begin
                    mask = (len >= 32) ? 32'hFFFF_FFFF : ((32'h1 << len) - 32'h1);
                    if ((slot_code[s] & mask) == (acc_bits & mask))
                    begin
                        produced     = 1'b1;
                        r.symbol     = slot_symbol[s];
                        r.code_error = 1'b0;
                    end
                end
            end
            if (!produced && int'(acc_count) >= ACC_LIMIT)
            begin
                produced     = 1'b1;
                r.symbol     = '0;
                r.code_error = 1'b1;
            end
            if (produced)
            begin
                acc_bits  = '0;
                acc_count = '0;
            end
        end
    endfunction

    function automatic beat_t load_beat(input int idx, input int sym, input logic [31:0] code,
                                        input int len);
        beat_t b;
        b            = '0;
        b.func       = FUNC_LOAD;
        b.index      = idx[IDX_W-1:0];
        b.symbol     = sym[SYM_W-1:0];
        b.code       = code;
        b.length     = len[LEN_W-1:0];
        b.stream_bit = 1'($urandom_range(0, 1));
        return b;
    endfunction

    function automatic beat_t bit_beat(input logic stream_bit);
        beat_t b;
        b            = '0;
        b.func       = FUNC_DECODE;
        b.index      = IDX_W'($urandom_range(0, 255));
        b.symbol     = SYM_W'($urandom_range(0, 255));
        b.code       = $urandom;
        b.length     = LEN_W'($urandom_range(0, 63));
        b.stream_bit = stream_bit;
        return b;
    endfunction

    // offer one beat, hold it until taken, then maybe open a gap
    task automatic send_beat(input beat_t b, input bit typed, input result_t typed_res);
        bit      produced;
        result_t r;
        int      gap;
        item_ch.valid        <= 1'b1;
        item_ch.func         <= b.func;
        item_ch.entry_index  <= b.index;
        item_ch.entry_symbol <= b.symbol;
        item_ch.entry_code   <= b.code;
        item_ch.entry_length <= b.length;
        item_ch.code_bit     <= b.stream_bit;
        offering = 1'b1;
        do @(posedge clk); while (!item_ch.ready);
        advance_decoder(b, produced, r);
        if (typed)
            expected_symbols.insert(expected_symbols.size(), typed_res);
        else if (produced)
            expected_symbols.insert(expected_symbols.size(), r);
        beats_sent++;
        if (burst_left == 0)
        begin
            item_ch.valid <= 1'b0;
            offering = 1'b0;
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 3);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 20);
        end
        else
        begin
            burst_left--;
        end
    endtask

    task automatic send_free(input beat_t b);
        send_beat(b, 1'b0, '0);
    endtask

    task automatic drain_results();
        if (offering)
        begin
            item_ch.valid <= 1'b0;
            offering = 1'b0;
        end
        while (expected_symbols.size() != 0)
            @(posedge clk);
    endtask

    // receiver: stall pattern drawn at random from four modes, plus one long hold-off on request
    initial
    begin
        int cyc;
        int mode;
        int hold_left;
        cyc       = 0;
        mode      = 0;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 50 == 0)
                mode = $urandom_range(0, 3);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: result_ch.ready <= 1'b1;
                    1: result_ch.ready <= 1'($urandom_range(0, 1));
                    2: result_ch.ready <= ($urandom_range(0, 4) == 0);
                    default: result_ch.ready <= (cyc % 3 != 0);
                endcase
            end
        end
    end

    // compare each taken result with the oldest expectation
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_symbols.size() == 0)
            begin
                $error("unexpected result: symbol %0h code_error %0b",
                       result_ch.symbol, result_ch.code_error);
                fail_count++;
            end
            else
            begin
                exp_r = expected_symbols.pop_front();
                if (result_ch.symbol !== exp_r.symbol)
                begin
                    $error("symbol: expected %0h, actual %0h", exp_r.symbol, result_ch.symbol);
                    fail_count++;
                end
                if (result_ch.code_error !== exp_r.code_error)
                begin
                    $error("code_error: expected %0b, actual %0b",
                           exp_r.code_error, result_ch.code_error);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int          leaf_code [64];
        int          leaf_len  [64];
        int          slot_order [TABLE_ENTRIES];
        int          used_slots [$];
        int          n_leaves;
        int          n_target;
        int          phase;
        int          pick;
        int          tmp;
        int          nsym;
        int          extra;
        int          drop_code;
        int          drop_len;
        bit          has_drop;
        logic [31:0] mask;
        logic [31:0] word;
        dir_row_t    row;
        beat_t       b;
        result_t     typed_res;

        fail_count   = 0;
        beats_sent   = 0;
        burst_left   = 0;
        idle_cycles  = 0;
        offering     = 1'b0;
        hold_off_req = 1'b0;
        acc_bits     = '0;
        acc_count    = '0;
        for (int s = 0; s < TABLE_ENTRIES; s++)
            slot_length[s] = '0;

        rst_n                <= 1'b0;
        item_ch.valid        <= 1'b0;
        item_ch.func         <= FUNC_LOAD;
        item_ch.entry_index  <= '0;
        item_ch.entry_symbol <= '0;
        item_ch.entry_code   <= '0;
        item_ch.entry_length <= '0;
        item_ch.code_bit     <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < DIR_ROWS; k++)
        begin
            row          = DIRECTED[k];
            b.func       = row.func;
            b.index      = row.index;
            b.symbol     = row.symbol;
            b.code       = row.code;
            b.length     = row.length;
            b.stream_bit = row.stream_bit;
            typed_res.symbol     = row.exp_symbol;
            typed_res.code_error = row.exp_error;
            send_beat(b, row.typed, typed_res);
        end

        // table is empty again: noise runs the accumulator into a code error
        repeat (40) send_free(bit_beat(1'($urandom_range(0, 1))));

        phase = 0;
        while (beats_sent < DIR_ROWS + 40 + RANDOM_BEATS)
        begin
            // build a prefix code by splitting leaves of a binary tree
            leaf_code[0] = 0;
            leaf_len[0]  = 1;
            leaf_code[1] = 1;
            leaf_len[1]  = 1;
            n_leaves     = 2;
            if ($urandom_range(0, 3) == 0)
                n_target = 33;
            else
                n_target = $urandom_range(2, 24);
            while (n_leaves < n_target)
            begin
                pick = (n_target == 33) ? 0 : $urandom_range(0, n_leaves - 1);
                if (leaf_len[pick] < 32)
                begin
                    leaf_code[n_leaves] = (leaf_code[pick] << 1) | 1;
                    leaf_len[n_leaves]  = leaf_len[pick] + 1;
                    leaf_code[pick]     = leaf_code[pick] << 1;
                    leaf_len[pick]      = leaf_len[pick] + 1;
                    n_leaves++;
                end
            end

            // drop a leaf now and then so that some paths never match
            has_drop = ($urandom_range(0, 2) == 0);
            if (has_drop)
            begin
                pick      = $urandom_range(0, n_leaves - 1);
                drop_code = leaf_code[pick];
                drop_len  = leaf_len[pick];
                leaf_code[pick] = leaf_code[n_leaves - 1];
                leaf_len[pick]  = leaf_len[n_leaves - 1];
                n_leaves--;
            end

            // empty the slots of the previous table
            while (used_slots.size() != 0)
                send_free(load_beat(used_slots.pop_front(), $urandom_range(0, 255), $urandom, 0));

            for (int s = 0; s < TABLE_ENTRIES; s++)
                slot_order[s] = s;
            for (int s = TABLE_ENTRIES - 1; s > 0; s--)
            begin
                pick            = $urandom_range(0, s);
                tmp             = slot_order[s];
                slot_order[s]   = slot_order[pick];
                slot_order[pick] = tmp;
            end

            // load the leaves with junk above the code length
            for (int j = 0; j < n_leaves; j++)
            begin
                mask = (leaf_len[j] >= 32) ? 32'hFFFF_FFFF : ((32'h1 << leaf_len[j]) - 32'h1);
                word = ($urandom & ~mask) | (leaf_code[j] & mask);
                send_free(load_beat(slot_order[j], $urandom_range(0, 255), word, leaf_len[j]));
                used_slots.insert(used_slots.size(), slot_order[j]);
            end
            extra = n_leaves;
            if ($urandom_range(0, 3) == 0)
            begin
                // duplicate code in another slot: lowest index wins
                pick = $urandom_range(0, n_leaves - 1);
                send_free(load_beat(slot_order[extra], $urandom_range(0, 255),
                                    leaf_code[pick], leaf_len[pick]));
                used_slots.insert(used_slots.size(), slot_order[extra]);
                extra++;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                // overlong entry: stored, never matches
                send_free(load_beat(slot_order[extra], $urandom_range(0, 255), $urandom,
                                    $urandom_range(33, 63)));
                used_slots.insert(used_slots.size(), slot_order[extra]);
            end

            if (phase == 2)
                hold_off_req = 1'b1;
            if (phase == 4)
                drain_results();

            nsym = $urandom_range(4, 16);
            for (int k = 0; k < nsym; k++)
            begin
                if (has_drop && $urandom_range(0, 5) == 0)
                begin
                    for (int bi = drop_len - 1; bi >= 0; bi--)
                        send_free(bit_beat(1'((drop_code >> bi) & 1)));
                    repeat ($urandom_range(0, 32 - drop_len))
                        send_free(bit_beat(1'($urandom_range(0, 1))));
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    repeat ($urandom_range(1, 8))
                        send_free(bit_beat(1'($urandom_range(0, 1))));
                end
                else
                begin
                    pick = $urandom_range(0, n_leaves - 1);
                    for (int bi = leaf_len[pick] - 1; bi >= 0; bi--)
                        send_free(bit_beat(1'((leaf_code[pick] >> bi) & 1)));
                end
            end
            phase++;
        end

        drain_results();
        repeat (TABLE_ENTRIES + 40) @(posedge clk);

        if (fail_count == 0 && expected_symbols.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
